// ===== src/ctb_pkg.sv =====
package ctb_pkg;

    // operation codes carried in the op field of a request item
    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_RESET = 3'd2,
        OP_QUERY = 3'd3,
        OP_TICK  = 3'd4
    } op_e;

    // how the sequencer treats an accepted item
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_SINGLE,
        KIND_TICK
    } kind_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_TICK,
        ST_DONE
    } state_e;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  timer_index;
        logic [31:0] timeout_value;
    } req_t;

    typedef struct packed {
        logic [31:0] count_value;
        logic        expired;
    } rsp_t;

    // sequencer strobes toward the datapath
    typedef struct packed {
        logic ready;
        logic rd_single;
        logic exec;
        logic tick_rd;
        logic done;
    } ctl_t;

endpackage

// ===== src/ctb_ram.sv =====
module ctb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ctb_ctrl.sv =====
module ctb_ctrl #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  ctb_pkg::kind_e       kind,
    input  logic                 out_free,
    output ctb_pkg::ctl_t        ctl,
    output logic [((NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1)-1:0] tick_addr
);

    import ctb_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);

    state_e           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctl.ready = 1'b1;
                if (accept)
                begin
                    cnt_next = '0;
                    unique case (kind)
                        KIND_SINGLE: state_next = ST_READ;
                        KIND_TICK:   state_next = ST_TICK;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_READ:
            begin
                ctl.rd_single = 1'b1;
                state_next    = ST_EXEC;
            end
            ST_EXEC:
            begin
                ctl.exec   = 1'b1;
                state_next = ST_DONE;
            end
            ST_TICK:
            begin
                // read entry cnt while the previous entry is written back
                if (cnt_reg == CNT_W'(NUM_TIMERS))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ctl.tick_rd = 1'b1;
                    cnt_next    = cnt_reg + CNT_W'(1);
                end
            end
            ST_DONE:
            begin
                ctl.done = 1'b1;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign tick_addr = cnt_reg[IDX_W-1:0];

endmodule

// ===== src/countdown_timer_bank.sv =====
// countdown_timer_bank: NUM_TIMERS down-counting timers sharing one decrement path
// start/stop/reset/query: ram read, update, then the result waits until the output slot is free
// tick: a sweep of every entry, one ram read and at most one write-back per cycle, overlapped
// unused op codes and indexes past the bank: no ram access, straight to the result
// one item in work at a time; a new item is taken while a result waits
// reset: all timers halted, counts read as zero through per-entry valid bits, no clearing pass
module countdown_timer_bank #(
    parameter int NUM_TIMERS  = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ctb_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ctb_pkg::rsp_t rsp
);

    import ctb_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    // request capture and sequencer
    req_t                   req_reg;
    kind_e                  kind;
    ctl_t                   ctl;
    logic [IDX_W-1:0]       tick_addr;
    logic                   accept;
    logic                   out_free;

    // count store ram and its side state
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic                   ram_re;
    logic [IDX_W-1:0]       ram_raddr;
    logic [COUNT_WIDTH-1:0] ram_q;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic                   tick_wb_reg;
    logic [NUM_TIMERS-1:0]  valid_reg;
    logic [NUM_TIMERS-1:0]  halted_reg;

    // shared update unit
    logic [COUNT_WIDTH-1:0] rd_cnt;
    logic                   rd_halted;
    logic [COUNT_WIDTH-1:0] new_cnt;
    logic                   new_halted;
    logic                   halted_we;
    logic [COUNT_WIDTH-1:0] dec_cnt;
    logic [COUNT_WIDTH-1:0] timeout_cnt;

    // result path
    rsp_t                   res_reg;
    rsp_t                   rsp_reg;
    logic                   rsp_valid_reg;

    assign req_ready = ctl.ready;
    assign accept    = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    // classify the incoming item; unused codes and indexes past the bank do nothing
    always_comb
    begin
        if (req.op == OP_TICK)
        begin
            kind = KIND_TICK;
        end
        else if ((req.op == OP_START || req.op == OP_STOP || req.op == OP_RESET ||
                  req.op == OP_QUERY) && (32'(req.timer_index) < 32'(NUM_TIMERS)))
        begin
            kind = KIND_SINGLE;
        end
        else
        begin
            kind = KIND_NONE;
        end
    end

    ctb_ctrl #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .kind      (kind),
        .out_free  (out_free),
        .ctl       (ctl),
        .tick_addr (tick_addr)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
    end

    // ram read: the addressed timer for a single op, the sweep pointer for a tick
    assign ram_re    = ctl.rd_single || ctl.tick_rd;
    assign ram_raddr = ctl.tick_rd ? tick_addr : IDX_W'(req_reg.timer_index);

    ctb_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_TIMERS)
    ) u_count_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            rd_idx_reg <= ram_raddr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_wb_reg <= 1'b0;
        end
        else
        begin
            tick_wb_reg <= ctl.tick_rd;
        end
    end

    // never-written entries read as zero
    assign rd_cnt      = valid_reg[rd_idx_reg] ? ram_q : '0;
    assign rd_halted   = halted_reg[rd_idx_reg];
    assign dec_cnt     = rd_cnt - COUNT_WIDTH'(1);
    assign timeout_cnt = req_reg.timeout_value[COUNT_WIDTH-1:0];

    always_comb
    begin
        ram_we     = 1'b0;
        ram_waddr  = rd_idx_reg;
        ram_wdata  = rd_cnt;
        new_cnt    = rd_cnt;
        new_halted = rd_halted;
        halted_we  = 1'b0;
        if (ctl.exec)
        begin
            unique case (req_reg.op)
                OP_START:
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = timeout_cnt;
                    new_cnt    = timeout_cnt;
                    new_halted = (timeout_cnt == '0);
                    halted_we  = 1'b1;
                end
                OP_STOP:
                begin
                    new_halted = 1'b1;
                    halted_we  = 1'b1;
                end
                OP_RESET:
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = '0;
                    new_cnt    = '0;
                    new_halted = 1'b1;
                    halted_we  = 1'b1;
                end
                default:
                begin
                    // query reads only
                end
            endcase
        end
        else if (tick_wb_reg && !rd_halted)
        begin
            // running timer: count down, halt on reaching zero
            ram_we    = 1'b1;
            ram_wdata = dec_cnt;
            new_cnt   = dec_cnt;
            if (dec_cnt == '0)
            begin
                new_halted = 1'b1;
                halted_we  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            halted_reg <= '1;
        end
        else
        begin
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (halted_we)
            begin
                halted_reg[rd_idx_reg] <= new_halted;
            end
        end
    end

    // result: zero unless a single op on a timer in the bank fills it in
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= '0;
        end
        else if (ctl.exec)
        begin
            res_reg.count_value <= 32'(new_cnt);
            res_reg.expired     <= new_halted && (new_cnt == '0);
        end
    end

    // output register, loaded when the sequencer finishes and the slot is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctl.done && out_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.done && out_free)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && ram_re |-> ram_waddr != ram_raddr)
        else $error("count ram read and write hit the same entry");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !ram_we && !halted_we)
        else $error("timer state written while idle");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("item accepted while the previous one is still in work");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(ctl.done))
        else $error("result raised without a finished item");

endmodule

// ===== tb/sv/countdown_timer_bank_test.sv =====
`timescale 1ns / 100ps

module countdown_timer_bank_test;
    import ctb_pkg::*;

    localparam int NUM_TIMERS  = 16;
    localparam int COUNT_WIDTH = 32;
    localparam int ITEMS_PER_PHASE = 282;
    localparam int LONG_HOLD_CYCLES = 400;
    // tick latency plus margin, for the quiet tail after the last result
    localparam int TAIL_CYCLES = NUM_TIMERS + 8;
    localparam int MAX_PRINTED = 40;

    // op codes the block must treat as no-ops
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    // directed rows either carry a typed-in result or defer to the predictor
    localparam bit KNOWN   = 1'b1;
    localparam bit PREDICT = 1'b0;

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_ready;
    req_t  req;
    logic  rsp_valid;
    logic  rsp_ready;
    rsp_t  rsp;

    // predictor state: one count and one halted flag per timer
    logic [COUNT_WIDTH-1:0] timer_counts [NUM_TIMERS];
    bit                     timer_halted [NUM_TIMERS];

    // results owed by the block, oldest first
    rsp_t pending_rsps [$];

    // pacing knobs, changed between phases
    int send_gap_pct;
    int recv_stall_pct;
    int hold_left;

    int mismatch_count;
    int items_sent;
    int ticks_sent;
    int results_seen;
    int expiries_seen;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  timer_index;
        logic [31:0] timeout_value;
        bit          known;
        logic [31:0] want_count;
        logic        want_expired;
    } dir_row_t;

    // directed table: reset state, extremes, every op, zero timeout, spare op codes
    dir_row_t directed_rows [25] = '{
        '{OP_QUERY,     4'd0,  32'h0000_0000, KNOWN,   32'h0000_0000, 1'b1}, // all halted at zero
        '{OP_QUERY,     4'd15, 32'hFFFF_FFFF, KNOWN,   32'h0000_0000, 1'b1}, // timeout ignored
        '{OP_STOP,      4'd4,  32'h0000_0000, KNOWN,   32'h0000_0000, 1'b1},
        '{OP_TICK,      4'd9,  32'hFFFF_FFFF, KNOWN,   32'h0000_0000, 1'b0}, // tick reports zero
        '{OP_START,     4'd0,  32'hFFFF_FFFF, KNOWN,   32'hFFFF_FFFF, 1'b0}, // largest timeout
        '{OP_START,     4'd15, 32'h0000_0000, KNOWN,   32'h0000_0000, 1'b1}, // zero halts at once
        '{OP_START,     4'd3,  32'h0000_0001, KNOWN,   32'h0000_0001, 1'b0},
        '{OP_START,     4'd8,  32'h0000_0002, KNOWN,   32'h0000_0002, 1'b0},
        '{OP_TICK,      4'd0,  32'h0000_0000, KNOWN,   32'h0000_0000, 1'b0},
        '{OP_QUERY,     4'd3,  32'h0000_0000, PREDICT, 32'h0000_0000, 1'b0}, // just expired
        '{OP_QUERY,     4'd0,  32'h0000_0000, PREDICT, 32'h0000_0000, 1'b0},
        '{OP_STOP,      4'd0,  32'h0000_0000, PREDICT, 32'h0000_0000, 1'b0},
        '{OP_TICK,      4'd15, 32'h0000_0000, KNOWN,   32'h0000_0000, 1'b0},
        '{OP_QUERY,     4'd0,  32'h0000_0000, PREDICT, 32'h0000_0000, 1'b0}, // stopped holds
        '{OP_QUERY,     4'd8,  32'h0000_0000, PREDICT, 32'h0000_0000, 1'b0},
        '{OP_START,     4'd0,  32'h8000_0000, KNOWN,   32'h8000_0000, 1'b0},
        '{OP_RESET,     4'd0,  32'hFFFF_FFFF, KNOWN,   32'h0000_0000, 1'b1},
        '{OP_START,     4'd7,  32'h7FFF_FFFF, KNOWN,   32'h7FFF_FFFF, 1'b0},
        '{OP_SPARE_LO,  4'd7,  32'hFFFF_FFFF, KNOWN,   32'h0000_0000, 1'b0},
        '{OP_SPARE_MID, 4'd15, 32'h0000_0005, KNOWN,   32'h0000_0000, 1'b0},
        '{OP_SPARE_HI,  4'd0,  32'h0000_0000, KNOWN,   32'h0000_0000, 1'b0},
        '{OP_TICK,      4'd5,  32'h0000_0000, KNOWN,   32'h0000_0000, 1'b0},
        '{OP_QUERY,     4'd7,  32'h0000_0000, PREDICT, 32'h0000_0000, 1'b0},
        '{OP_STOP,      4'd7,  32'h0000_0000, PREDICT, 32'h0000_0000, 1'b0},
        '{OP_START,     4'd7,  32'h0000_0000, KNOWN,   32'h0000_0000, 1'b1}  // restart with zero
    };

    // per-phase pacing: none, sender idle, receiver stall, both
    int gap_pct_by_phase   [4] = '{0, 48, 0, 14};
    int stall_pct_by_phase [4] = '{0, 0, 48, 14};

    countdown_timer_bank #(
        .NUM_TIMERS  (NUM_TIMERS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // applies one item to the predicted timer bank, returns the result it owes
    function automatic rsp_t timer_bank_apply(req_t item);
        rsp_t res;
        int   idx;
        res = '0;
        idx = item.timer_index;
        if (item.op == OP_TICK)
        begin
            // every running timer steps down, halting when it lands on zero
            for (int t = 0; t < NUM_TIMERS; t++)
            begin
                if (!timer_halted[t])
                begin
                    timer_counts[t] = timer_counts[t] - 1'b1;
                    if (timer_counts[t] == '0)
                        timer_halted[t] = 1'b1;
                end
            end
            return res;
        end
        // spare op codes and out-of-range timers leave the bank alone
        if (item.op > OP_QUERY || idx >= NUM_TIMERS)
            return res;
        case (item.op)
            OP_START:
            begin
                timer_counts[idx] = item.timeout_value[COUNT_WIDTH-1:0];
                timer_halted[idx] = (item.timeout_value[COUNT_WIDTH-1:0] == '0);
            end
            OP_STOP:
                timer_halted[idx] = 1'b1;
            OP_RESET:
            begin
                timer_halted[idx] = 1'b1;
                timer_counts[idx] = '0;
            end
            default:
                ;
        endcase
        res.count_value = 32'(timer_counts[idx]);
        res.expired     = timer_halted[idx] && (timer_counts[idx] == '0);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
    endtask

    // offers one item, holding it until taken, then books its expected result
    task automatic offer_request(input req_t item, input bit known, input rsp_t known_rsp);
        rsp_t predicted;
        while ($urandom_range(99) < send_gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        // taken at this edge; predictor always runs so its state stays in step
        predicted = timer_bank_apply(item);
        pending_rsps.push_back(known ? known_rsp : predicted);
        items_sent++;
        if (item.op == OP_TICK)
            ticks_sent++;
    endtask

    // sender parks valid and waits until the block has returned everything
    task automatic drain_results();
        req_valid <= 1'b0;
        while (pending_rsps.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random stalls, or a long hold-off when one is requested
    initial
    begin
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker: every taken result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            results_seen++;
            if (rsp.expired)
                expiries_seen++;
            if (pending_rsps.size() == 0)
                report_mismatch("result with nothing pending", rsp.count_value, '0);
            else
            begin
                if (rsp.count_value !== pending_rsps[0].count_value)
                    report_mismatch("count_value", rsp.count_value,
                                    pending_rsps[0].count_value);
                if (rsp.expired !== pending_rsps[0].expired)
                    report_mismatch("expired", 32'(rsp.expired),
                                    32'(pending_rsps[0].expired));
                void'(pending_rsps.pop_front());
            end
        end
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        req_t item;
        rsp_t want;
        int   sel;

        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        mismatch_count = 0;
        items_sent     = 0;
        ticks_sent     = 0;
        results_seen   = 0;
        expiries_seen  = 0;
        for (int t = 0; t < NUM_TIMERS; t++)
        begin
            timer_counts[t] = '0;
            timer_halted[t] = 1'b1;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed table, no idling
        foreach (directed_rows[r])
        begin
            item.op            = directed_rows[r].op;
            item.timer_index   = directed_rows[r].timer_index;
            item.timeout_value = directed_rows[r].timeout_value;
            want.count_value   = directed_rows[r].want_count;
            want.expired       = directed_rows[r].want_expired;
            offer_request(item, directed_rows[r].known, want);
        end
        drain_results();

        for (int ph = 0; ph < 4; ph++)
        begin
            @(negedge clk);
            send_gap_pct   = gap_pct_by_phase[ph];
            recv_stall_pct = stall_pct_by_phase[ph];
            // first phase opens with a long receiver hold-off so the block backs up
            if (ph == 0)
                hold_left = LONG_HOLD_CYCLES;
            @(posedge clk);

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                sel                = $urandom_range(99);
                item.timer_index   = 4'($urandom_range(NUM_TIMERS - 1));
                item.timeout_value = '0;
                if (sel < 28)
                begin
                    // mostly short timeouts so ticks actually drive timers to expiry
                    item.op = OP_START;
                    case ($urandom_range(19))
                        0, 1:       item.timeout_value = '0;
                        2, 3, 4:    item.timeout_value = $urandom();
                        default:    item.timeout_value = $urandom_range(1, 6);
                    endcase
                end
                else if (sel < 58)
                    item.op = OP_TICK;
                else if (sel < 78)
                    item.op = OP_QUERY;
                else if (sel < 86)
                    item.op = OP_STOP;
                else if (sel < 94)
                    item.op = OP_RESET;
                else if (sel < 97)
                    item.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                else
                begin
                    // raw noise across every field
                    item.op            = 3'($urandom_range(7));
                    item.timer_index   = 4'($urandom_range(15));
                    item.timeout_value = $urandom();
                end
                offer_request(item, PREDICT, '0);
            end
            // sender pauses here until the block has handed back every result
            drain_results();
        end

        // quiet tail: anything arriving now is unexpected
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("ran %0d items (%0d ticks) through four pacing phases plus a long hold-off",
                 items_sent, ticks_sent);
        $display("checked %0d results, %0d of them reporting an expired timer",
                 results_seen, expiries_seen);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/ctb_pkg.sv
src/ctb_ram.sv
src/ctb_ctrl.sv
src/countdown_timer_bank.sv
tb/sv/countdown_timer_bank_test.sv
